// ===== hw/rtl/ibfr_pkg.sv =====
// Package for the iBus frame receiver: header codes, widths, ALU op codes
// and the structs passed between the controller and the channel store.
// No dependencies.
package ibfr_pkg;

    // Field widths fixed by the frame format.
    localparam int BYTE_W   = 8;
    localparam int CH_IDX_W = 4;
    localparam int CH_VAL_W = 16;
    localparam int POS_W    = 5;
    localparam int SUM_W    = 13;

    // Header bytes and checksum base.
    localparam logic [BYTE_W-1:0]   HDR_LEN = 8'h20;
    localparam logic [BYTE_W-1:0]   HDR_CMD = 8'h40;
    localparam logic [CH_VAL_W-1:0] CK_BASE = 16'hFFFF;

    // Parse phase codes.
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_CMD  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    // Shared ALU operations.
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    // Byte write into the channel store.
    typedef struct packed {
        logic                we;
        logic                hi;
        logic [CH_IDX_W-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } t_store_wr;

    // Word read from the channel store.
    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] addr;
    } t_store_rd;

endpackage

// ===== hw/rtl/ibfr_if.sv =====
// Handshake interfaces for the iBus frame receiver: the received byte
// channel and the decoded channel-value channel. Depends on ibfr_pkg.
interface ibfr_byte_if;
    import ibfr_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface ibfr_chan_if;
    import ibfr_pkg::*;
    logic                valid;
    logic                ready;
    logic [CH_IDX_W-1:0] channel_index;
    logic [CH_VAL_W-1:0] channel_value;
    logic                last_channel;
    modport source(output valid, output channel_index, output channel_value,
                   output last_channel, input ready);
    modport sink(input valid, input channel_index, input channel_value,
                 input last_channel, output ready);
endinterface

// ===== hw/rtl/ibus_frame_receiver_core.sv =====
// iBus frame receiver: hunts for the 0x20 0x40 header, collects channel
// words, checks the frame checksum and emits the channel values.
// Each received byte is captured, then processed in a separate state; the input is not ready meanwhile.
// After the last checksum byte of a good frame, each channel is read from the store
// and then presented, one at a time, holding until the sink is ready; no bytes are taken meanwhile.
// Reset (synchronous, active low) returns to the header hunt; the store is not cleared.
module ibus_frame_receiver_core #(
    parameter int NUM_CHANNELS = 14,
    parameter int FRAME_BYTES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ibfr_byte_if.sink   i_rx,
    ibfr_chan_if.source o_ch
);
    import ibfr_pkg::*;

    logic                alu_op;
    logic [CH_VAL_W-1:0] alu_a;
    logic [CH_VAL_W-1:0] alu_b;
    logic [CH_VAL_W-1:0] alu_y;
    t_store_wr           st_wr;
    t_store_rd           st_rd;
    logic [CH_VAL_W-1:0] st_rd_data;

    // Sequencer.
    ibfr_ctrl #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_rx.valid),
        .o_in_ready (i_rx.ready),
        .i_in_byte  (i_rx.rx_byte),
        .o_out_valid(o_ch.valid),
        .i_out_ready(o_ch.ready),
        .o_out_index(o_ch.channel_index),
        .o_out_last (o_ch.last_channel),
        .o_alu_op   (alu_op),
        .o_alu_a    (alu_a),
        .o_alu_b    (alu_b),
        .i_alu_y    (alu_y),
        .o_wr       (st_wr),
        .o_rd       (st_rd)
    );

    // Shared add/subtract unit.
    ibfr_alu u_alu (
        .i_op(alu_op),
        .i_a (alu_a),
        .i_b (alu_b),
        .o_y (alu_y)
    );

    // Channel word store.
    ibfr_store #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr     (st_wr),
        .i_rd     (st_rd),
        .o_rd_data(st_rd_data)
    );

    assign o_ch.channel_value = st_rd_data;
endmodule

// ===== hw/rtl/ibfr_alu.sv =====
// Shared 16-bit add/subtract unit used for the running sum and the
// checksum check. Depends on ibfr_pkg.
module ibfr_alu (
    input  logic                          i_op,
    input  logic [ibfr_pkg::CH_VAL_W-1:0] i_a,
    input  logic [ibfr_pkg::CH_VAL_W-1:0] i_b,
    output logic [ibfr_pkg::CH_VAL_W-1:0] o_y
);
    import ibfr_pkg::*;

    // One adder, with the second operand inverted for subtraction.
    always_comb begin
        case (i_op)
            ALU_ADD: o_y = i_a + i_b;
            ALU_SUB: o_y = i_a - i_b;
            default: o_y = i_a + i_b;
        endcase
    end
endmodule

// ===== hw/rtl/ibfr_store.sv =====
// Channel word store for the iBus frame receiver: byte-wide writes into
// 16-bit entries and a registered word read. Depends on ibfr_pkg.
module ibfr_store #(
    parameter int NUM_CHANNELS = 14
) (
    input  logic                          i_clk,
    input  ibfr_pkg::t_store_wr           i_wr,
    input  ibfr_pkg::t_store_rd           i_rd,
    output logic [ibfr_pkg::CH_VAL_W-1:0] o_rd_data
);
    import ibfr_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [CH_VAL_W-1:0] r_mem [NUM_CHANNELS];
    logic [CH_VAL_W-1:0] r_rd_data;

    // Byte write into the low or high half of one entry.
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            if (i_wr.hi) begin
                r_mem[i_wr.addr[AW-1:0]][CH_VAL_W-1:BYTE_W] <= i_wr.data;
            end else begin
                r_mem[i_wr.addr[AW-1:0]][BYTE_W-1:0] <= i_wr.data;
            end
        end
    end

    // Registered read; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== hw/rtl/ibfr_ctrl.sv =====
// Sequencer of the iBus frame receiver: header hunt, byte collection,
// checksum check through the shared ALU and channel emission.
// Depends on ibfr_pkg.
module ibfr_ctrl #(
    parameter int NUM_CHANNELS = 14,
    parameter int FRAME_BYTES  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Byte input handshake.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ibfr_pkg::BYTE_W-1:0]   i_in_byte,
    // Channel output handshake.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ibfr_pkg::CH_IDX_W-1:0] o_out_index,
    output logic                          o_out_last,
    // Shared ALU.
    output logic                          o_alu_op,
    output logic [ibfr_pkg::CH_VAL_W-1:0] o_alu_a,
    output logic [ibfr_pkg::CH_VAL_W-1:0] o_alu_b,
    input  logic [ibfr_pkg::CH_VAL_W-1:0] i_alu_y,
    // Channel store.
    output ibfr_pkg::t_store_wr           o_wr,
    output ibfr_pkg::t_store_rd           o_rd
);
    import ibfr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PROC = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [POS_W-1:0]    P_CK_LO  = POS_W'(FRAME_BYTES - 2);
    localparam logic [POS_W-1:0]    N_CH     = POS_W'(NUM_CHANNELS);
    localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(NUM_CHANNELS - 1);

    logic [1:0]          r_state, n_state;
    logic [1:0]          r_phase, n_phase;
    logic [POS_W-1:0]    r_pos,   n_pos;
    logic [SUM_W-1:0]    r_sum,   n_sum;
    logic [BYTE_W-1:0]   r_ck_lo, n_ck_lo;
    logic [BYTE_W-1:0]   r_byte,  n_byte;
    logic [CH_IDX_W-1:0] r_cnt,   n_cnt;

    logic [POS_W-1:0]    data_off;
    logic [CH_IDX_W-1:0] data_ch;

    // Offset into the data bytes and the channel it belongs to.
    assign data_off = r_pos - POS_W'(2);
    assign data_ch  = data_off[POS_W-1:1];

    // Next-state and datapath control.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_ck_lo = r_ck_lo;
        n_byte  = r_byte;
        n_cnt   = r_cnt;
        o_alu_op = ALU_ADD;
        o_alu_a  = CH_VAL_W'(r_sum);
        o_alu_b  = CH_VAL_W'(r_byte);
        o_wr.we   = 1'b0;
        o_wr.hi   = data_off[0];
        o_wr.addr = data_ch;
        o_wr.data = r_byte;
        o_rd.en   = 1'b0;
        o_rd.addr = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_in_byte;
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                n_state = S_IDLE;
                case (r_phase)
                    PH_CMD: begin
                        if (r_byte == HDR_CMD) begin
                            n_phase = PH_DATA;
                            n_pos   = POS_W'(2);
                            n_sum   = SUM_W'(HDR_LEN) + SUM_W'(HDR_CMD);
                        end else if (r_byte != HDR_LEN) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    PH_DATA: begin
                        if (r_pos < P_CK_LO) begin
                            // Data byte: add into the sum and store if it maps to a channel.
                            n_sum = i_alu_y[SUM_W-1:0];
                            n_pos = r_pos + POS_W'(1);
                            if (r_pos >= POS_W'(2) && {1'b0, data_ch} < N_CH) begin
                                o_wr.we = 1'b1;
                            end
                        end else if (r_pos == P_CK_LO) begin
                            n_ck_lo = r_byte;
                            n_pos   = r_pos + POS_W'(1);
                        end else begin
                            // Checksum high byte: compare against base minus sum.
                            o_alu_op = ALU_SUB;
                            o_alu_a  = CK_BASE;
                            o_alu_b  = CH_VAL_W'(r_sum);
                            if (i_alu_y == {r_byte, r_ck_lo}) begin
                                n_cnt   = '0;
                                n_state = S_RD;
                            end
                            n_phase = PH_HUNT;
                            n_pos   = '0;
                        end
                    end
                    default: begin
                        // Hunt, and the unused phase code behaves as the hunt.
                        n_phase = (r_byte == HDR_LEN) ? PH_CMD : PH_HUNT;
                    end
                endcase
            end
            S_RD: begin
                o_rd.en = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_cnt == LAST_IDX) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt + CH_IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_sum   <= '0;
            r_ck_lo <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_ck_lo <= n_ck_lo;
            r_cnt   <= n_cnt;
        end
    end

    // Captured input byte.
    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_index = r_cnt;
    assign o_out_last  = (r_cnt == LAST_IDX);
endmodule
